>>> rtl/core/tpg_pkg.sv
// ----------------------------------------------------------------------------
// tpg_pkg
// Types and constants shared by the triangle pulse generator modules.
// ----------------------------------------------------------------------------
package tpg_pkg;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_PULSE  = 2'd1;
  localparam logic [1:0] REG_PHASE  = 2'd2;
  localparam logic [1:0] REG_LEVELS = 2'd3;

  localparam logic [15:0] PERIOD_RST = 16'd60;
  localparam logic [15:0] PULSE_RST  = 16'd40;
  localparam logic [15:0] PHASE_RST  = 16'd0;
  localparam logic [8:0]  LEVELS_RST = 9'd64;

  // shared divider: divisor up to 2*pulse (17 bits), remainder one bit more
  localparam int unsigned DIV_W = 17;
  localparam int unsigned REM_W = DIV_W + 1;
  // quantizer quotient is below 256
  localparam int unsigned QUOT_W = 8;

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] pulse;
    logic [15:0] phase;
    logic [8:0]  levels;
  } tpg_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tpg_div_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_MOD,
    ST_MUL,
    ST_QDIV,
    ST_QWAIT,
    ST_DONE
  } tpg_state_e;

endpackage

>>> rtl/core/triangle_pulse_generator.sv
// ----------------------------------------------------------------------------
// triangle_pulse_generator
// Periodic triangular pulse generator. Each input tick folds the sample
// counter into the period and quantizes the triangle height at that point.
//
//   channel   dir  handshake                 payload
//   s_axis    in   tvalid/tready             tdata[0] restart
//   m_axis    out  tvalid/tready             tdata[7:0] level, [23:8] position
//   apb       in   psel/penable, pready=1    period, pulse, phase, levels
//
// A tick skips the period fold when the count sits on the phase and the
// quantization when the level is known to be zero; the shared
// one-bit-per-cycle divider serves the period fold (NUM_W steps) and then
// the rounded quantization (8 steps).
// Reset leaves the counter at zero and the registers at their defaults.
// A waiting result sits in the output register; the next tick is accepted
// meanwhile and its result waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module triangle_pulse_generator #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input ticks
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] restart, [7:1] zero
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [7:0] level, [23:8] position
);
  import tpg_pkg::*;

  localparam int unsigned NUM_W = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
  localparam int unsigned SC_W  = $clog2(NUM_W + 1);
  localparam int unsigned CMP_W = NUM_W + 1;

  tpg_cfg_t         cfg;
  tpg_div_sts_t     div_sts;
  tpg_state_e       state_q, state_d;

  logic [TIME_WIDTH-1:0] cnt_q, cnt_d;
  logic [TIME_WIDTH-1:0] cur_q, cur_d;
  logic                  lt_q, lt_d;
  logic [15:0]           pos_q, pos_d;
  logic [23:0]           prod_q, prod_d;
  logic [7:0]            lvl_q, lvl_d;
  logic                  mv_q, mv_d;
  logic [7:0]            out_lvl_q, out_lvl_d;
  logic [15:0]           out_pos_q, out_pos_d;

  logic                  in_acc;
  logic [TIME_WIDTH-1:0] cur_in;
  logic [CMP_W-1:0]      c_ext, p_ext, diff;
  logic [15:0]           per;
  logic [7:0]            lvm1;
  logic                  rise, fall;
  logic [15:0]           rsel;
  logic [25:0]           qnum;
  logic                  out_free;

  logic                  div_start;
  logic [SC_W-1:0]       div_steps;
  logic [REM_W-1:0]      div_rem_in;
  logic [NUM_W-1:0]      div_num_in;
  logic [DIV_W-1:0]      div_div_in;
  logic [REM_W-1:0]      div_rem;
  logic [NUM_W-1:0]      div_quot;

  tpg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tpg_div #(
    .NUM_W (NUM_W),
    .SC_W  (SC_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .steps_i (div_steps),
    .rem_i   (div_rem_in),
    .num_i   (div_num_in),
    .div_i   (div_div_in),
    .rem_o   (div_rem),
    .quot_o  (div_quot),
    .sts_o   (div_sts)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cur_in          = s_axis_tdata_i[0] ? '0 : cnt_q;
  assign out_free        = !mv_q || m_axis_tready_i;

  // period fold operands
  assign per   = (cfg.period == 16'd0) ? 16'd1 : cfg.period;
  assign c_ext = {{(CMP_W-TIME_WIDTH){1'b0}}, cur_q};
  assign p_ext = {{(CMP_W-16){1'b0}}, cfg.phase};
  assign diff  = (c_ext < p_ext) ? (p_ext - c_ext) : (c_ext - p_ext - 1'b1);

  // level clamp to 2..256, as levels - 1
  always_comb begin
    if (cfg.levels < 9'd2) begin
      lvm1 = 8'd1;
    end else if (cfg.levels > 9'd256) begin
      lvm1 = 8'd255;
    end else begin
      lvm1 = 8'(cfg.levels - 9'd1);
    end
  end

  // rise while 2*pos <= w, fall while pos < w
  assign rise = {pos_q, 1'b0} <= {1'b0, cfg.pulse};
  assign fall = !rise && (pos_q < cfg.pulse);
  assign rsel = rise ? pos_q : (cfg.pulse - pos_q);

  // ((levels-1)*4*r + w) / (2*w); quotient is below 256
  assign qnum = {prod_q, 2'b00} + {10'd0, cfg.pulse};

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cur_d      = cur_q;
    lt_d       = lt_q;
    pos_d      = pos_q;
    prod_d     = prod_q;
    lvl_d      = lvl_q;
    mv_d       = mv_q;
    out_lvl_d  = out_lvl_q;
    out_pos_d  = out_pos_q;
    div_start  = 1'b0;
    div_steps  = SC_W'(NUM_W);
    div_rem_in = '0;
    div_num_in = diff[NUM_W-1:0];
    div_div_in = {1'b0, per};

    if (mv_q && m_axis_tready_i) begin
      mv_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cur_d   = cur_in;
          cnt_d   = cur_in + 1'b1;
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        lt_d = c_ext < p_ext;
        if (c_ext == p_ext) begin
          pos_d   = 16'd0;
          state_d = ST_MUL;
        end else begin
          div_start = 1'b1;
          state_d   = ST_MOD;
        end
      end
      ST_MOD: begin
        if (div_sts.done) begin
          if (lt_q) begin
            pos_d = (div_rem == '0) ? 16'd0 : (per - div_rem[15:0]);
          end else begin
            pos_d = div_rem[15:0] + 16'd1;
          end
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d = lvm1 * rsel;
        if ((cfg.pulse == 16'd0) || !(rise || fall)) begin
          lvl_d   = 8'd0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_QDIV;
        end
      end
      ST_QDIV: begin
        div_start  = 1'b1;
        div_steps  = SC_W'(QUOT_W);
        div_rem_in = qnum[25:QUOT_W];
        div_num_in = {qnum[QUOT_W-1:0], {(NUM_W-QUOT_W){1'b0}}};
        div_div_in = {cfg.pulse, 1'b0};
        state_d    = ST_QWAIT;
      end
      ST_QWAIT: begin
        if (div_sts.done) begin
          lvl_d   = div_quot[QUOT_W-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          mv_d      = 1'b1;
          out_lvl_d = lvl_q;
          out_pos_d = pos_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    lt_q      <= lt_d;
    pos_q     <= pos_d;
    prod_q    <= prod_d;
    lvl_q     <= lvl_d;
    out_lvl_q <= out_lvl_d;
    out_pos_q <= out_pos_d;
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = {out_pos_q, out_lvl_q};

  a_count_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (cnt_q == cur_q + 1'b1))
    else $error("sample counter did not advance past the accepted tick");

  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_sts.busy)
    else $error("ready while the divider is still working");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == ST_MOD || state_q == ST_QWAIT))
    else $error("divider finished outside a wait state");

endmodule

>>> rtl/core/tpg_regs.sv
// ----------------------------------------------------------------------------
// tpg_regs
// APB register file: period, pulse width, phase and level count.
// ----------------------------------------------------------------------------
module tpg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tpg_pkg::tpg_cfg_t cfg_o
);
  import tpg_pkg::*;

  tpg_cfg_t   cfg_q;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period <= PERIOD_RST;
      cfg_q.pulse  <= PULSE_RST;
      cfg_q.phase  <= PHASE_RST;
      cfg_q.levels <= LEVELS_RST;
    end else if (wr_en) begin
      case (idx)
        REG_PERIOD: cfg_q.period <= pwdata[15:0];
        REG_PULSE:  cfg_q.pulse  <= pwdata[15:0];
        REG_PHASE:  cfg_q.phase  <= pwdata[15:0];
        REG_LEVELS: cfg_q.levels <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PERIOD: prdata = {16'd0, cfg_q.period};
      REG_PULSE:  prdata = {16'd0, cfg_q.pulse};
      REG_PHASE:  prdata = {16'd0, cfg_q.phase};
      REG_LEVELS: prdata = {23'd0, cfg_q.levels};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/tpg_div.sv
// ----------------------------------------------------------------------------
// tpg_div
// Shared restoring divider, one quotient bit per cycle. The caller preloads
// the partial remainder and the dividend bits still to be shifted in (MSB
// aligned); the quotient collects in the low bits of the dividend register.
// ----------------------------------------------------------------------------
module tpg_div #(
  parameter int unsigned NUM_W = 16,
  parameter int unsigned SC_W  = $clog2(NUM_W + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [SC_W-1:0]            steps_i,
  input  logic [tpg_pkg::REM_W-1:0]  rem_i,
  input  logic [NUM_W-1:0]           num_i,
  input  logic [tpg_pkg::DIV_W-1:0]  div_i,
  output logic [tpg_pkg::REM_W-1:0]  rem_o,
  output logic [NUM_W-1:0]           quot_o,
  output tpg_pkg::tpg_div_sts_t      sts_o
);
  import tpg_pkg::*;

  logic              busy_q;
  logic [SC_W-1:0]   cnt_q;
  logic [REM_W-1:0]  rem_q;
  logic [NUM_W-1:0]  num_q;
  logic [DIV_W-1:0]  div_q;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // rem_q < div_q, so its top bit is always clear
  assign trial = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      num_q <= num_i;
      div_q <= div_i;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= ge ? (trial - {1'b0, div_q}) : trial;
      num_q <= {num_q[NUM_W-2:0], ge};
    end
  end

  assign rem_o      = rem_q;
  assign quot_o     = num_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = busy_q && (cnt_q == '0);

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < {1'b0, div_q}))
    else $error("partial remainder not below divisor");

endmodule

>>> bench/tpg_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpg_check
// Watches the register port and both streams of the triangle pulse generator,
// predicts level and position for every accepted tick request and compares
// them with the results in order. Reports the number of failures and how many
// results are still owed.
// ----------------------------------------------------------------------------
module tpg_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  input  logic        tick_valid_i,
  input  logic        tick_ready_i,
  input  logic [7:0]  tick_data_i,   // [0] restart, [7:1] zero
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [23:0] res_data_i,    // [7:0] level, [23:8] position
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import tpg_pkg::*;

  localparam int unsigned REPORT_MAX = 10;

  // packed MSB first, so position sits above level as on the bus
  typedef struct packed {
    logic [15:0] position;
    logic [7:0]  level;
  } sample_t;

  tpg_cfg_t    cfg = '{PERIOD_RST, PULSE_RST, PHASE_RST, LEVELS_RST};
  logic [15:0] sample_count = '0;
  sample_t     owed_samples[$];
  sample_t     got, want;
  int unsigned fails = 0;

  function automatic sample_t predict_sample(logic [15:0] cnt);
    int unsigned per, ph, c, rem, pos, w, lv, ramp;
    sample_t s;
    per = (cfg.period == 16'd0) ? 1 : cfg.period;
    ph  = cfg.phase;
    c   = cnt;
    // a position equal to the period is kept, not folded to zero
    if (c < ph) begin
      rem = (ph - c) % per;
      pos = (rem == 0) ? 0 : per - rem;
    end else if (c == ph) begin
      pos = 0;
    end else begin
      pos = ((c - ph - 1) % per) + 1;
    end
    w  = cfg.pulse;
    lv = (cfg.levels < 9'd2) ? 2 : (cfg.levels > 9'd256) ? 256 : cfg.levels;
    s.position = 16'(pos);
    s.level    = '0;
    if (w != 0 && pos < w) begin
      ramp    = (2 * pos <= w) ? pos : w - pos;
      // round half up of (lv-1) * ramp / (w/2)
      s.level = 8'(((lv - 1) * 4 * ramp + w) / (2 * w));
    end else if (w != 0 && 2 * pos <= w) begin
      s.level = 8'(((lv - 1) * 4 * pos + w) / (2 * w));
    end
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg          = '{PERIOD_RST, PULSE_RST, PHASE_RST, LEVELS_RST};
      sample_count = '0;
      owed_samples.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_PERIOD: cfg.period = pwdata_i[15:0];
          REG_PULSE:  cfg.pulse  = pwdata_i[15:0];
          REG_PHASE:  cfg.phase  = pwdata_i[15:0];
          REG_LEVELS: cfg.levels = pwdata_i[8:0];
          default: ;
        endcase
      end
      // a result always leaves after its request, so compare before pushing
      if (res_valid_i && res_ready_i) begin
        got = res_data_i;
        if (owed_samples.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("%0t: result with nothing owed: level %0d position %0d",
                     $realtime, got.level, got.position);
        end else begin
          want = owed_samples.pop_front();
          if (got.level !== want.level || got.position !== want.position) begin
            fails++;
            if (fails <= REPORT_MAX)
              $display("%0t: level exp %0d got %0d, position exp %0d got %0d",
                       $realtime, want.level, got.level, want.position, got.position);
          end
        end
      end
      if (tick_valid_i && tick_ready_i) begin
        if (tick_data_i[0]) sample_count = '0;
        owed_samples.push_back(predict_sample(sample_count));
        sample_count = sample_count + 16'd1;
      end
    end
    fail_count_o <= fails;
    pending_o    <= owed_samples.size();
  end

endmodule

>>> bench/triangle_pulse_generator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_pulse_generator_test
// Drives tick requests and register writes into the triangle pulse generator:
// a short directed sweep of register extremes, a run with zero pulse width,
// then random settings and ticks under several idle and stall mixes.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module triangle_pulse_generator_test;
  import tpg_pkg::*;

  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned ZERO_PULSE_TICKS = 100;
  localparam int unsigned SETTINGS_PER_MIX = 5;
  localparam int unsigned TICKS_PER_SETTING = 55;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        tick_valid = 1'b0;
  logic        tick_ready;
  logic [7:0]  tick_data = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [23:0] res_data;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned idle_cycles = 0;

  int unsigned send_idle_mix[4] = '{0, 56, 0, 29};
  int unsigned stall_mix[4]     = '{0, 0, 56, 29};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triangle_pulse_generator dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (tick_valid),
    .s_axis_tready_o (tick_ready),
    .s_axis_tdata_i  (tick_data),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_data)
  );

  tpg_check u_tpg_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .tick_valid_i (tick_valid),
    .tick_ready_i (tick_ready),
    .tick_data_i  (tick_data),
    .res_valid_i  (res_valid),
    .res_ready_i  (res_ready),
    .res_data_i   (res_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((tick_valid && tick_ready) || (res_valid && res_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("triangle_pulse_generator: mismatch");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // called in the step of the last acceptance; pending is registered in the checker and lags the queue
  task automatic settle();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // upper data bits carry junk, the block keeps only the register width
  task automatic configure(input logic [15:0] period, input logic [15:0] pulse,
                           input logic [15:0] phase, input logic [8:0] levels);
    settle();
    write_reg(REG_PERIOD, ($urandom() & 32'hFFFF_0000) | period);
    write_reg(REG_PULSE,  ($urandom() & 32'hFFFF_0000) | pulse);
    write_reg(REG_PHASE,  ($urandom() & 32'hFFFF_0000) | phase);
    write_reg(REG_LEVELS, ($urandom() & 32'hFFFF_FE00) | levels);
  endtask

  task automatic send_tick(input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick_data  <= {7'b0, restart};
    @(posedge clk);
    while (!tick_ready) @(posedge clk);
  endtask

  task automatic run_ticks(input int unsigned num, input logic restart_first);
    for (int unsigned i = 0; i < num; i++)
      send_tick((i == 0) ? restart_first : 1'b0);
  endtask

  task automatic random_config();
    logic [15:0] period, pulse, phase;
    logic [8:0]  levels;
    case ($urandom_range(9))
      0:       period = 16'd0;
      1:       period = 16'hFFFF;
      2:       period = 16'd1;
      default: period = 16'($urandom_range(1, 200));
    endcase
    case ($urandom_range(7))
      0:       pulse = 16'd0;
      1:       pulse = 16'hFFFF;
      2:       pulse = 16'd1;
      default: pulse = 16'($urandom_range(1, (period < 16'd200) ? 2 * period + 2 : 400));
    endcase
    case ($urandom_range(7))
      0:       phase = 16'd0;
      1:       phase = 16'hFFFF;
      2:       phase = 16'($urandom_range(65535));
      default: phase = 16'($urandom_range(300));
    endcase
    case ($urandom_range(9))
      0:       levels = 9'd0;
      1:       levels = 9'd1;
      2:       levels = 9'd2;
      3:       levels = 9'd256;
      4:       levels = 9'd257;
      5:       levels = 9'd511;
      6:       levels = 9'($urandom_range(511));
      default: levels = 9'($urandom_range(2, 256));
    endcase
    configure(period, pulse, phase, levels);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, then zero period, full-scale registers, a small
    // triangle hitting rise, fall, the zero tail and position == period
    run_ticks(4, 1'b0);
    configure(16'd0, 16'd1, 16'd0, 9'd2);
    run_ticks(4, 1'b1);
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd511);
    run_ticks(3, 1'b1);
    configure(16'd7, 16'd6, 16'd3, 9'd256);
    run_ticks(11, 1'b1);
    configure(16'd5, 16'd0, 16'd2, 9'd1);
    run_ticks(3, 1'b1);
    configure(16'd40000, 16'hFFFF, 16'd0, 9'd257);
    run_ticks(3, 1'b1);

    // zero pulse width: short ticks, level stays zero
    configure(16'd1000, 16'd0, 16'd100, 9'd64);
    run_ticks(ZERO_PULSE_TICKS, 1'b1);
    configure(16'd1000, 16'd300, 16'd100, 9'd200);
    send_idle_pct = 29;
    stall_pct     = 29;
    run_ticks(100, 1'b0);

    for (int m = 0; m < 4; m++) begin
      send_idle_pct = send_idle_mix[m];
      stall_pct     = stall_mix[m];
      for (int k = 0; k < SETTINGS_PER_MIX; k++) begin
        random_config();
        for (int i = 0; i < TICKS_PER_SETTING; i++)
          send_tick($urandom_range(99) < 4);
      end
    end

    settle();
    if (fail_count == 0)
      $display("triangle_pulse_generator: match");
    else
      $display("triangle_pulse_generator: mismatch");
    $finish;
  end

endmodule

>>> triangle_pulse_generator.f
rtl/core/tpg_pkg.sv
rtl/core/tpg_regs.sv
rtl/core/tpg_div.sv
rtl/core/triangle_pulse_generator.sv
bench/tpg_check.sv
bench/triangle_pulse_generator_test.sv
